>>> design/multi_priority_event_queue_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the priority event queue
// Shared assertion forms, clocked on the rising edge, muted in reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_PRIORITY_EVENT_QUEUE_TOP_DEFINES_SVH
`define MULTI_PRIORITY_EVENT_QUEUE_TOP_DEFINES_SVH

// property holds in the same cycle
`define MPQ_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mpq_pkg.sv
// ---------------------------------------------------------------------------
// mpq_pkg
// Sizes, codes, command/status types and index helpers of the event queue.
// ---------------------------------------------------------------------------
package mpq_pkg;

	localparam int NUM_PRIORITIES = 4;
	localparam int QUEUE_DEPTH    = 16;
	localparam int IDX_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int Q_W            = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
	localparam int SLOTS          = NUM_PRIORITIES * QUEUE_DEPTH;
	localparam int ADDR_W         = $clog2(SLOTS);
	localparam int PRIO_W         = 3;
	localparam int EVENT_W        = 16;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_type_t;

	typedef enum logic [0:0] {
		S_IDLE,
		S_READ
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic enq_write;  // store word at tail of the named queue
		logic deq_start;  // read head slot, advance head
		logic ld_direct;  // load response that needs no memory data
		logic ld_read;    // load response from registered read data
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_is_deq;
		logic deq_found;
		logic out_free;
	} dp_status_t;

	// indices count down and wrap from slot 0 to the top slot
	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == '0) r = IDX_W'(QUEUE_DEPTH - 1);
		else           r = idx - IDX_W'(1);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [Q_W-1:0] q,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
	endfunction

endpackage

>>> design/mpq_req_if.sv
// ---------------------------------------------------------------------------
// mpq_req_if
// Request channel: enqueue or dequeue word with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mpq_req_if import mpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [PRIO_W-1:0]  prio_in;
	logic [EVENT_W-1:0] event_in;

	modport source (output valid, req_type, prio_in, event_in, input ready);
	modport sink   (input valid, req_type, prio_in, event_in, output ready);
endinterface

>>> design/mpq_rsp_if.sv
// ---------------------------------------------------------------------------
// mpq_rsp_if
// Response channel: status, dequeued event and its priority.
// ---------------------------------------------------------------------------
interface mpq_rsp_if import mpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [EVENT_W-1:0] event_out;
	logic [PRIO_W-1:0]  prio_out;

	modport source (output valid, ok, event_out, prio_out, input ready);
	modport sink   (input valid, ok, event_out, prio_out, output ready);
endinterface

>>> design/mpq_ctrl.sv
// ---------------------------------------------------------------------------
// mpq_ctrl
// Request sequencer: takes a word, issues datapath commands, waits on reads.
// ---------------------------------------------------------------------------
module mpq_ctrl import mpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   accept;

	// take a word only when the response register can hold the result
	assign req_ready = (state_q == S_IDLE) && status.out_free;
	assign accept    = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && status.req_is_deq && status.deq_found) state_d = S_READ;
			end
			S_READ:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (status.req_is_deq && status.deq_found) begin
						cmd.deq_start = 1'b1;
					end else begin
						cmd.enq_write = !status.req_is_deq;
						cmd.ld_direct = 1'b1;
					end
				end
			end
			S_READ:  cmd.ld_read = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

>>> design/mpq_dp.sv
// ---------------------------------------------------------------------------
// mpq_dp
// Queue pointers, event memory, priority select and response register.
// ---------------------------------------------------------------------------
`include "multi_priority_event_queue_top_defines.svh"

module mpq_dp import mpq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               req_type,
	input  logic [PRIO_W-1:0]  prio_in,
	input  logic [EVENT_W-1:0] event_in,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               ok,
	output logic [EVENT_W-1:0] event_out,
	output logic [PRIO_W-1:0]  prio_out
);

	logic [IDX_W-1:0]   head_q [NUM_PRIORITIES];
	logic [IDX_W-1:0]   tail_q [NUM_PRIORITIES];
	logic [NUM_PRIORITIES-1:0] full_q;
	logic [EVENT_W-1:0] mem_q [SLOTS];
	logic [EVENT_W-1:0] rd_data_q;
	logic [PRIO_W-1:0]  rd_prio_q;

	logic               valid_q, ok_q;
	logic [EVENT_W-1:0] event_q;
	logic [PRIO_W-1:0]  prio_q;

	logic               prio_ok, enq_ok, deq_found;
	logic [Q_W-1:0]     enq_q, deq_q;
	logic [IDX_W-1:0]   tail_next;
	logic [NUM_PRIORITIES-1:0] nonempty;

	// enqueue target and its checks
	assign prio_ok   = (prio_in != '0) && (32'(prio_in) <= 32'(NUM_PRIORITIES));
	assign enq_q     = Q_W'(prio_in - PRIO_W'(1));
	assign enq_ok    = prio_ok && !full_q[enq_q];
	assign tail_next = step_down(tail_q[enq_q]);

	// highest non-empty queue wins
	always_comb begin
		deq_found = 1'b0;
		deq_q     = '0;
		for (int q = 0; q < NUM_PRIORITIES; q++) begin
			nonempty[q] = (head_q[q] != tail_q[q]) || full_q[q];
			if (nonempty[q]) begin
				deq_found = 1'b1;
				deq_q     = Q_W'(q);
			end
		end
	end

	assign status.req_is_deq = (req_type == REQ_DEQ);
	assign status.deq_found  = deq_found;
	assign status.out_free   = !valid_q || rsp_ready;

	// head, tail and full flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_PRIORITIES; q++) begin
				head_q[q] <= IDX_W'(QUEUE_DEPTH - 1);
				tail_q[q] <= IDX_W'(QUEUE_DEPTH - 1);
			end
			full_q <= '0;
		end else begin
			if (cmd.enq_write && enq_ok) begin
				tail_q[enq_q] <= tail_next;
				if (tail_next == head_q[enq_q]) full_q[enq_q] <= 1'b1;
			end
			if (cmd.deq_start) begin
				head_q[deq_q] <= step_down(head_q[deq_q]);
				full_q[deq_q] <= 1'b0;
			end
		end
	end

	// event memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.enq_write && enq_ok) mem_q[slot_addr(enq_q, tail_q[enq_q])] <= event_in;
		if (cmd.deq_start) begin
			rd_data_q <= mem_q[slot_addr(deq_q, head_q[deq_q])];
			rd_prio_q <= PRIO_W'(deq_q) + PRIO_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.ld_direct || cmd.ld_read) valid_q <= 1'b1;
		else if (rsp_ready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_direct) begin
			ok_q    <= !status.req_is_deq && enq_ok;
			event_q <= '0;
			prio_q  <= '0;
		end else if (cmd.ld_read) begin
			ok_q    <= 1'b1;
			event_q <= rd_data_q;
			prio_q  <= rd_prio_q;
		end
	end

	assign rsp_valid = valid_q;
	assign ok        = ok_q;
	assign event_out = event_q;
	assign prio_out  = prio_q;

	// checks
	`MPQ_ASSERT(a_deq_needs_data, clk, arst_n, cmd.deq_start |-> deq_found, "dequeue with all queues empty")
	`MPQ_ASSERT(a_enq_not_full, clk, arst_n, (cmd.enq_write && enq_ok) |-> !full_q[enq_q], "write into full queue")
	`MPQ_ASSERT_NEXT(a_read_resp, clk, arst_n, cmd.ld_read, valid_q && ok_q && (prio_q != '0), "read response not loaded")
	`MPQ_ASSERT(a_load_free, clk, arst_n, (cmd.ld_direct || cmd.ld_read) |-> status.out_free, "response overwritten")
	`MPQ_ASSERT(a_full_meet, clk, arst_n, (full_q[enq_q] && prio_ok) |-> (head_q[enq_q] == tail_q[enq_q]), "full queue with head apart from tail")

endmodule

>>> design/multi_priority_event_queue_top.sv
// ---------------------------------------------------------------------------
// multi_priority_event_queue_top
// Strict-priority set of circular event FIFOs with request/response words.
// ---------------------------------------------------------------------------
// An enqueue, or a dequeue that finds every queue empty, is accepted from
// S_IDLE and its response word appears in the response register the next
// cycle, so such requests run at one per cycle while responses are taken. A
// successful dequeue passes through the S_READ state: the event memory read is
// registered, and the sequencer holds off the next request while in S_READ. No
// request is taken while a response waits and is not being taken that cycle.
// The event memory is not cleared after reset; only written slots are read.
module multi_priority_event_queue_top import mpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req_type  (req.req_type),
		.prio_in   (req.prio_in),
		.event_in  (req.event_in),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ok        (rsp.ok),
		.event_out (rsp.event_out),
		.prio_out  (rsp.prio_out)
	);

endmodule
